[hw/rtl/hcbd_pkg.sv]
// Shared types, constants and helpers for the chunked body decoder.
`default_nettype none
package hcbd_pkg;

	localparam int unsigned COUNT_WIDTH = 32;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	localparam logic [1:0] TRAILER_LEN = 2'd2;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_DONE    = 1'b1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       new_body;
	} body_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       kind;
	} dec_beat_t;

	typedef enum logic [3:0] {
		PH_SIZE  = 4'b0001,
		PH_DATA  = 4'b0010,
		PH_TRAIL = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		SC_LEAD   = 3'b001,
		SC_DIGITS = 3'b010,
		SC_REST   = 3'b100
	} scan_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b0;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok  = 1'b1;
			h.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.ok  = 1'b1;
			h.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.ok  = 1'b1;
			h.val = 4'(c - 8'h37);
		end
		return h;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/http_chunked_body_decoder_core.sv]
// Top level of the HTTP chunked body decoder: byte register, decode logic, result register.
//
// channel | dir | handshake            | payload
// body    | in  | body_valid/body_stall| body (in_byte, new_body)
// dec     | out | dec_valid/dec_stall  | dec (out_byte, kind)
//
// One byte per cycle sustained while dec is not stalled; each beat waits in the byte register and the
// decode of it (state update, result) completes when it leaves for the result register.
// arst_n clears the byte and result valids and puts the decoder at a fresh size line.
// A stall on dec holds the result; body stalls only when the byte register is full and
// the result register cannot take its beat.
`default_nettype none
module http_chunked_body_decoder_core (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      body_valid,
	output logic                     body_stall,
	input  wire hcbd_pkg::body_beat_t body,
	output logic                     dec_valid,
	input  wire                      dec_stall,
	output hcbd_pkg::dec_beat_t      dec
);

	localparam int unsigned CW = hcbd_pkg::COUNT_WIDTH;

	logic                 valid_s1;
	hcbd_pkg::body_beat_t beat_s1;

	hcbd_pkg::phase_t phase_q, phase_d, phase_c;
	hcbd_pkg::scan_t  scan_q, scan_d, scan_c;
	logic [CW-1:0]    accum_q, accum_d, accum_c;
	logic [CW-1:0]    left_q, left_d, left_c, left_m1;
	logic [1:0]       trail_q, trail_d, trail_c, trail_m1;
	logic             cr_q, cr_d, cr_c;

	logic                res_v;
	hcbd_pkg::dec_beat_t res;
	hcbd_pkg::hex_t      hx;
	logic                out_free;
	logic                adv;

	assign out_free   = !dec_valid || !dec_stall;
	assign adv        = valid_s1 && out_free;
	assign body_stall = valid_s1 && !out_free;

	// Byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!body_stall) begin
			valid_s1 <= body_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!body_stall && body_valid) begin
			beat_s1 <= body;
		end
	end

	// Decode
	always_comb begin
		// new_body restarts the decoder before this byte
		phase_c = beat_s1.new_body ? hcbd_pkg::PH_SIZE : phase_q;
		scan_c  = beat_s1.new_body ? hcbd_pkg::SC_LEAD : scan_q;
		accum_c = beat_s1.new_body ? '0 : accum_q;
		left_c  = beat_s1.new_body ? '0 : left_q;
		trail_c = beat_s1.new_body ? 2'd0 : trail_q;
		cr_c    = beat_s1.new_body ? 1'b0 : cr_q;

		hx       = hcbd_pkg::hex_digit(beat_s1.in_byte);
		left_m1  = left_c - CW'(1);
		trail_m1 = trail_c - 2'd1;

		phase_d = phase_c;
		scan_d  = scan_c;
		accum_d = accum_c;
		left_d  = left_c;
		trail_d = trail_c;
		cr_d    = cr_c;
		res_v   = 1'b0;
		res     = '0;

		case (phase_c)
			hcbd_pkg::PH_SIZE: begin
				if (beat_s1.in_byte == hcbd_pkg::CH_LF && cr_c) begin
					cr_d = 1'b0;
					if (accum_c == '0) begin
						phase_d  = hcbd_pkg::PH_DONE;
						res_v    = 1'b1;
						res.kind = hcbd_pkg::KIND_DONE;
					end else begin
						left_d  = accum_c;
						phase_d = hcbd_pkg::PH_DATA;
					end
				end else begin
					cr_d = (beat_s1.in_byte == hcbd_pkg::CH_CR);
					if (scan_c == hcbd_pkg::SC_LEAD &&
					    (beat_s1.in_byte == hcbd_pkg::CH_SP ||
					     beat_s1.in_byte == hcbd_pkg::CH_TAB)) begin
						scan_d = scan_c;
					end else if (scan_c == hcbd_pkg::SC_LEAD ||
					             scan_c == hcbd_pkg::SC_DIGITS) begin
						if (hx.ok) begin
							// saturate once the top nibble is in use
							if (accum_c[CW-1 -: 4] != 4'd0) begin
								accum_d = '1;
							end else begin
								accum_d = {accum_c[CW-5:0], hx.val};
							end
							scan_d = hcbd_pkg::SC_DIGITS;
						end else begin
							scan_d = hcbd_pkg::SC_REST;
						end
					end
				end
			end
			hcbd_pkg::PH_DATA: begin
				res_v        = 1'b1;
				res.out_byte = beat_s1.in_byte;
				res.kind     = hcbd_pkg::KIND_PAYLOAD;
				left_d       = left_m1;
				if (left_m1 == '0) begin
					phase_d = hcbd_pkg::PH_TRAIL;
					trail_d = hcbd_pkg::TRAILER_LEN;
				end
			end
			hcbd_pkg::PH_TRAIL: begin
				trail_d = trail_m1;
				if (trail_m1 == 2'd0) begin
					phase_d = hcbd_pkg::PH_SIZE;
					accum_d = '0;
					scan_d  = hcbd_pkg::SC_LEAD;
					cr_d    = 1'b0;
				end
			end
			default: begin
				phase_d = phase_c;
			end
		endcase
	end

	// Decoder state, advance with each beat leaving the byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcbd_pkg::PH_SIZE;
			scan_q  <= hcbd_pkg::SC_LEAD;
			accum_q <= '0;
			left_q  <= '0;
			trail_q <= 2'd0;
			cr_q    <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_d;
			scan_q  <= scan_d;
			accum_q <= accum_d;
			left_q  <= left_d;
			trail_q <= trail_d;
			cr_q    <= cr_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_valid <= 1'b0;
		end else if (adv && res_v) begin
			dec_valid <= 1'b1;
		end else if (!dec_stall) begin
			dec_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_v) begin
			dec <= res;
		end
	end

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec.kind == hcbd_pkg::KIND_DONE |-> dec.out_byte == 8'd0)
		else $error("done beat carries nonzero byte");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == hcbd_pkg::PH_DATA |-> left_q != '0)
		else $error("payload phase with no bytes left");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		body_stall |-> valid_s1 && dec_valid && dec_stall)
		else $error("body stalled without a full pipeline");

	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dec_valid) |-> $past(valid_s1))
		else $error("result without a byte in flight");

endmodule
`default_nettype wire

[verif/http_chunked_body_decoder_core_test.sv]
// Self-checking testbench for the HTTP chunked body decoder core.
`timescale 1ns / 1ps
module http_chunked_body_decoder_core_test;

	localparam int ITEM_TARGET  = 1500;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int CALM_TAIL    = 200;

	class chunked_body_scoreboard;
		hcbd_pkg::phase_t                 phase;
		hcbd_pkg::scan_t                  scan;
		logic                             saw_cr;
		logic [hcbd_pkg::COUNT_WIDTH-1:0] size_acc;
		logic [hcbd_pkg::COUNT_WIDTH-1:0] data_left;
		logic [1:0]                       trail_left;
		hcbd_pkg::dec_beat_t              expected_dec[$];
		int                               errors;
		int                               n_payload;
		int                               n_done;
		int                               n_restart;

		function new();
			restart();
			errors    = 0;
			n_payload = 0;
			n_done    = 0;
			n_restart = 0;
		endfunction

		function void new_line();
			phase    = hcbd_pkg::PH_SIZE;
			size_acc = '0;
			scan     = hcbd_pkg::SC_LEAD;
			saw_cr   = 1'b0;
		endfunction

		function void restart();
			new_line();
			data_left  = '0;
			trail_left = '0;
		endfunction

		function void digit_value(input logic [7:0] c, output bit ok, output logic [3:0] v);
			ok = 1'b1;
			v  = 4'd0;
			if (c >= "0" && c <= "9")
				v = 4'(c - "0");
			else if (c >= "a" && c <= "f")
				v = 4'(c - "a" + 10);
			else if (c >= "A" && c <= "F")
				v = 4'(c - "A" + 10);
			else
				ok = 1'b0;
		endfunction

		// Advance the decoder state by one body beat and queue any result it yields.
		function void note_body(input hcbd_pkg::body_beat_t b);
			logic [7:0]                       c;
			bit                               ok;
			logic [3:0]                       v;
			logic [hcbd_pkg::COUNT_WIDTH-1:0] cap;
			logic [hcbd_pkg::COUNT_WIDTH-1:0] dv;
			c = b.in_byte;
			if (b.new_body) begin
				restart();
				n_restart++;
			end
			case (phase)
				hcbd_pkg::PH_SIZE: begin
					if (c == hcbd_pkg::CH_LF && saw_cr) begin
						saw_cr = 1'b0;
						if (size_acc == '0) begin
							phase = hcbd_pkg::PH_DONE;
							expected_dec.push_back({8'h00, hcbd_pkg::KIND_DONE});
							n_done++;
						end else begin
							data_left = size_acc;
							phase     = hcbd_pkg::PH_DATA;
						end
					end else begin
						saw_cr = (c == hcbd_pkg::CH_CR);
						if (!(scan == hcbd_pkg::SC_LEAD &&
						      (c == hcbd_pkg::CH_SP || c == hcbd_pkg::CH_TAB)) &&
						    scan != hcbd_pkg::SC_REST) begin
							digit_value(c, ok, v);
							if (ok) begin
								cap      = '1;
								dv       = '0;
								dv[3:0]  = v;
								if (size_acc > (cap - dv) / 16)
									size_acc = cap;
								else
									size_acc = size_acc * 16 + dv;
								scan = hcbd_pkg::SC_DIGITS;
							end else begin
								scan = hcbd_pkg::SC_REST;
							end
						end
					end
				end
				hcbd_pkg::PH_DATA: begin
					expected_dec.push_back({c, hcbd_pkg::KIND_PAYLOAD});
					n_payload++;
					data_left = data_left - 1'b1;
					if (data_left == '0) begin
						phase      = hcbd_pkg::PH_TRAIL;
						trail_left = hcbd_pkg::TRAILER_LEN;
					end
				end
				hcbd_pkg::PH_TRAIL: begin
					trail_left = trail_left - 1'b1;
					if (trail_left == 2'd0)
						new_line();
				end
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_dec.size();
		endfunction

		function void check_dec(input hcbd_pkg::dec_beat_t got);
			hcbd_pkg::dec_beat_t want;
			if (expected_dec.size() == 0) begin
				errors++;
				$display("@%0t unexpected beat: out_byte %02h kind %0d",
					$time, got.out_byte, got.kind);
				return;
			end
			want = expected_dec.pop_front();
			if (got.out_byte !== want.out_byte) begin
				errors++;
				$display("@%0t out_byte mismatch: expected %02h actual %02h",
					$time, want.out_byte, got.out_byte);
			end
			if (got.kind !== want.kind) begin
				errors++;
				$display("@%0t kind mismatch: expected %0d actual %0d",
					$time, want.kind, got.kind);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 body_valid = 1'b0;
	logic                 body_stall;
	hcbd_pkg::body_beat_t body = '0;
	logic                 dec_valid;
	logic                 dec_stall = 1'b0;
	hcbd_pkg::dec_beat_t  dec;

	chunked_body_scoreboard sb;
	bit idle_on = 1'b1;
	bit restart_next = 1'b0;
	int bytes_sent = 0;
	int stall_left = 0;
	int bodies = 0;

	http_chunked_body_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.body_valid(body_valid),
		.body_stall(body_stall),
		.body      (body),
		.dec_valid (dec_valid),
		.dec_stall (dec_stall),
		.dec       (dec)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver back-pressure in random bursts.
	always @(negedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (idle_on && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 15);
		if (!idle_on)
			stall_left = 0;
		dec_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin
		if (arst_n && dec_valid && !dec_stall)
			sb.check_dec(dec);
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (body_valid && !body_stall) || (dec_valid && !dec_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("@%0t watchdog: no beat moved for %0d cycles, %0d results outstanding",
			$time, QUIET_LIMIT, sb.pending());
		$display("http_chunked_body_decoder_core_test: errors");
		$finish;
	end

	task automatic send_beat(input hcbd_pkg::body_beat_t b);
		int gap;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 15);
			@(negedge clk);
			body_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		body_valid <= 1'b1;
		body       <= b;
		do @(posedge clk); while (body_stall);
		sb.note_body(b);
		bytes_sent++;
	endtask

	task automatic send_byte(input logic [7:0] c);
		hcbd_pkg::body_beat_t b;
		b.in_byte  = c;
		b.new_body = restart_next;
		restart_next = 1'b0;
		send_beat(b);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_crlf();
		send_byte(hcbd_pkg::CH_CR);
		send_byte(hcbd_pkg::CH_LF);
	endtask

	// Hold the sender until every queued result has come out.
	task automatic wait_results_drained();
		@(negedge clk);
		body_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(input int v, input bit upper);
		if (v < 10)
			return 8'(8'h30 + v);
		return 8'((upper ? 8'h41 : 8'h61) + v - 10);
	endfunction

	task automatic send_size_line(input int unsigned size, input bit oversize);
		string digits;
		logic [7:0] c;
		repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
			send_byte($urandom_range(0, 1) ? hcbd_pkg::CH_SP : hcbd_pkg::CH_TAB);
		if (oversize) begin
			send_byte(hex_char($urandom_range(1, 15), 1'($urandom_range(0, 1))));
			repeat ($urandom_range(8, 15))
				send_byte(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
		end else begin
			repeat (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0)
				send_byte("0");
			digits = $sformatf("%0h", size);
			for (int i = 0; i < digits.len(); i++) begin
				c = digits[i];
				if (c >= "a" && $urandom_range(0, 1))
					c = c - 8'h20;
				send_byte(c);
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			send_byte(";");
			repeat ($urandom_range(1, 5))
				send_byte(8'($urandom_range(33, 126)));
			// a lone CR inside the extension must not end the line
			if ($urandom_range(0, 1))
				send_byte(hcbd_pkg::CH_CR);
			send_byte(8'($urandom_range(33, 126)));
		end
		send_crlf();
	endtask

	task automatic send_end_line();
		case ($urandom_range(0, 5))
			0: begin
				repeat ($urandom_range(0, 2)) send_byte(hcbd_pkg::CH_SP);
				send_crlf();
			end
			1: begin
				send_text("0x1F");
				send_crlf();
			end
			2: begin
				send_text($urandom_range(0, 1) ? "-3" : "+0");
				send_crlf();
			end
			default: send_size_line(0, 1'b0);
		endcase
	endtask

	task automatic send_random_body();
		int          pick;
		int unsigned size;
		int          cut;
		restart_next = 1'b1;
		pick = $urandom_range(0, 19);
		if (pick < 2) begin
			// raw noise with the odd restart
			repeat ($urandom_range(4, 30)) begin
				if ($urandom_range(0, 9) == 0)
					restart_next = 1'b1;
				send_byte(8'($urandom_range(0, 255)));
			end
			return;
		end
		if (pick == 2) begin
			// saturated size, then abandon the body partway
			send_size_line(0, 1'b1);
			repeat ($urandom_range(1, 20))
				send_byte(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(1, 4)) begin
			pick = $urandom_range(0, 15);
			if (pick < 11)
				size = $urandom_range(1, 8);
			else if (pick < 15)
				size = $urandom_range(9, 64);
			else
				size = $urandom_range(100, 300);
			send_size_line(size, 1'b0);
			cut = ($urandom_range(0, 14) == 0) ? $urandom_range(0, size - 1) : size;
			for (int i = 0; i < cut; i++)
				send_byte(8'($urandom_range(0, 255)));
			if (cut != size)
				return;
			if ($urandom_range(0, 1))
				send_crlf();
			else begin
				send_byte(8'($urandom_range(0, 255)));
				send_byte(8'($urandom_range(0, 255)));
			end
		end
		send_end_line();
		// bytes after the final chunk are ignored
		repeat ($urandom_range(0, 3))
			send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// blanks before the size, extension, payload extremes, done, ignored byte after done
		restart_next = 1'b1;
		send_byte(hcbd_pkg::CH_TAB);
		send_text(" 2;");
		send_crlf();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("xx");
		send_text("0");
		send_crlf();
		send_text("A");
		// sign prefix leaves an empty size
		restart_next = 1'b1;
		send_text("-F");
		send_crlf();
		// lone CR ends the digits, later CR LF ends the line
		restart_next = 1'b1;
		send_text("1");
		send_byte(hcbd_pkg::CH_CR);
		send_text("B");
		send_crlf();
		send_byte(8'h5A);
		send_crlf();
		wait_results_drained();

		while (bytes_sent < ITEM_TARGET) begin
			if (bytes_sent > ITEM_TARGET - CALM_TAIL)
				idle_on = 1'b0;
			else
				idle_on = ($urandom_range(0, 3) != 0);
			send_random_body();
			bodies++;
			if (bodies % 40 == 0)
				wait_results_drained();
		end

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.errors++;
		$display("Sent %0d body bytes over %0d bodies with %0d restarts.",
			bytes_sent, bodies, sb.n_restart);
		$display("Checked %0d payload bytes and %0d end-of-body marks, %0d mismatches.",
			sb.n_payload, sb.n_done, sb.errors);
		if (sb.errors == 0)
			$display("http_chunked_body_decoder_core_test: clean");
		else
			$display("http_chunked_body_decoder_core_test: errors");
		$finish;
	end

endmodule
